FILE: src/ssrs_pkg.sv
// ---------------------------------------------------------------------------
// ssrs_pkg - shared types and constants
// Event codes, action codes, controller/datapath bundles, mode decode.
// ---------------------------------------------------------------------------
package ssrs_pkg;

    // event kinds (s_tuser)
    localparam logic [1:0] OP_CALL   = 2'd0;
    localparam logic [1:0] OP_RETURN = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // mismatch actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SUSPEND = 2'd1;
    localparam logic [1:0] ACT_PAUSE   = 2'd2;

    // error_mode codes
    localparam logic [1:0] MODE_SUSPEND = 2'd1;
    localparam logic [1:0] MODE_PAUSE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CHECK_ENABLE    = 2'd0;
    localparam logic [1:0] REG_CHECK_FREQUENCY = 2'd1;
    localparam logic [1:0] REG_ERROR_MODE      = 2'd2;

    localparam int OP_W      = 2;
    localparam int SITE_W    = 32;
    localparam int ACT_W     = 2;
    localparam int CNT_W     = 16;
    localparam int DVD_W     = CNT_W + 1;   // counter + 1 may reach 2^16
    localparam int STEP_W    = 5;           // counts DVD_W remainder steps
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_USER_W = 8;
    localparam int OUT_DAT_W = 8;

    // one result item; mismatch sits in the lowest bit
    typedef struct packed {
        logic             stack_fault;
        logic [ACT_W-1:0] error_action;
        logic             mismatch;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // controller -> datapath
    typedef struct packed {
        logic push;        // write site at top, top + 1
        logic pop;         // read top - 1, top - 1, hold site
        logic cnt_fast;    // counter <= counter + 1 (or 0 at wrap)
        logic div_start;   // load remainder unit
        logic div_step;    // one remainder step
        logic div_wr;      // counter <= final remainder
        logic res_imm;     // result with no compare
        logic res_fault;   // fault bit for res_imm
        logic res_cmp;     // result from stored entry compare
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_call;
        logic is_ret;
        logic is_tick;
        logic active;      // checking enabled and counter at zero
        logic full;
        logic empty;
        logic tick_fast;   // counter + 1 within wrap value
        logic div_last;    // final remainder step
    } status_t;

    function automatic logic [ACT_W-1:0] action_for_mode(input logic [1:0] mode);
        logic [ACT_W-1:0] act;
        case (mode)
            MODE_SUSPEND: act = ACT_SUSPEND;
            MODE_PAUSE:   act = ACT_PAUSE;
            default:      act = ACT_NONE;
        endcase
        return act;
    endfunction

endpackage

FILE: src/sampled_shadow_return_stack_unit.sv
// ---------------------------------------------------------------------------
// sampled_shadow_return_stack_unit - sampled shadow return stack
// Usage:
//   s_* channel takes one event item: s_tuser = kind (call/return/tick),
//   s_tdata = call-site address. m_* channel gives one result item per
//   event: mismatch, error action, stack fault.
//   cfg_* channel writes check_enable (0), check_frequency (1) and
//   error_mode (2); write only while no item is in flight. cfg_ready is
//   always high; other indexes are dropped.
//   m_tvalid rises in the cycle after input accept for call, tick and ignored
//   events; a checked return first passes the compare state (registered read
//   of the return store), and a tick whose counter sits at or above the wrap
//   value after a reconfig first runs the 17-step bit-serial remainder unit.
//   One item is worked on at a time and s_tready stays low while a result
//   waits, so a new event is taken only once the previous result has been
//   accepted by the receiver.
//   If the receiver stalls the result is held in the output register and
//   no further item is taken.
//   Reset: stack empty, job counter zero, checking off, frequency 1,
//   mode none. The return store itself is not cleared.
// ---------------------------------------------------------------------------
module sampled_shadow_return_stack_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // event input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssrs_pkg::SITE_W-1:0]       s_tdata,   // [31:0] call-site address
    input  logic [ssrs_pkg::IN_USER_W-1:0]    s_tuser,   // [1:0] opcode, [7:2] zero
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssrs_pkg::OUT_DAT_W-1:0]    m_tdata,   // [0] mismatch,
                                                         // [2:1] error_action,
                                                         // [3] stack_fault, [7:4] zero
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssrs_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import ssrs_pkg::*;

    cmd_t    cmd;
    status_t status;
    res_t    res;

    // config writes always taken; block is idle by contract
    assign cfg_ready = 1'b1;

    ssrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ssrs_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .opcode    (s_tuser[OP_W-1:0]),
        .site_addr (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .res       (res)
    );

    // result packed from bit 0 up, zero filled to a byte
    assign m_tdata = {(OUT_DAT_W - RES_W)'(0), res};

`ifndef SYNTHESIS
    // no new item while a result is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("item accepted with result pending");

    // pointer can never be both at zero and at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.full && status.empty))
        else $error("stack pointer full and empty at once");

    // a fault never comes with a compare mismatch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[0])
        else $error("fault and mismatch together");

    // error action only with a mismatch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[2:1] == ACT_NONE))
        else $error("action without mismatch");

    // a push or pop only while checking is live
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.pop) |-> status.active)
        else $error("stack moved while checking inactive");
`endif

endmodule

FILE: src/ssrs_ram.sv
// ---------------------------------------------------------------------------
// ssrs_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ssrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ssrs_dp.sv
// ---------------------------------------------------------------------------
// ssrs_dp - shadow stack datapath
// Config registers, stack pointer, return store, job counter with a
// bit-serial remainder unit, result register.
// ---------------------------------------------------------------------------
module ssrs_dp #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write
    input  logic                               cfg_we,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssrs_pkg::CFG_DAT_W-1:0]     cfg_data,
    // incoming item fields
    input  logic [ssrs_pkg::OP_W-1:0]          opcode,
    input  logic [ssrs_pkg::SITE_W-1:0]        site_addr,
    // control
    input  ssrs_pkg::cmd_t                     cmd,
    output ssrs_pkg::status_t                  status,
    output ssrs_pkg::res_t                     res
);
    import ssrs_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] TOP_FULL = PW'(STACK_DEPTH);

    // config
    logic              enable_reg;
    logic [CNT_W-1:0]  freq_reg;
    logic [1:0]        mode_reg;

    // stack
    logic [PW-1:0]     top_reg, top_next;
    logic [SITE_W-1:0] site_reg;
    logic [SITE_W-1:0] rdata;
    logic [PW-1:0]     top_dec;

    // job counter and remainder unit
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  freq_eff;
    logic [DVD_W-1:0]  cnt_inc;
    logic [DVD_W-1:0]  trial;
    logic [DVD_W-1:0]  trial_sub;

    res_t              res_reg, res_next;
    logic              cmp_mis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            freq_reg   <= CNT_W'(1);
            mode_reg   <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHECK_ENABLE:    enable_reg <= cfg_data[0];
                REG_CHECK_FREQUENCY: freq_reg   <= cfg_data;
                REG_ERROR_MODE:      mode_reg   <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // decode and status
    assign freq_eff  = (freq_reg == '0) ? CNT_W'(1) : freq_reg;
    assign cnt_inc   = {1'b0, cnt_reg} + DVD_W'(1);
    assign top_dec   = top_reg - PW'(1);

    assign status.is_call   = (opcode == OP_CALL);
    assign status.is_ret    = (opcode == OP_RETURN);
    assign status.is_tick   = (opcode == OP_TICK);
    assign status.active    = enable_reg && (cnt_reg == '0);
    assign status.full      = (top_reg == TOP_FULL);
    assign status.empty     = (top_reg == '0);
    assign status.tick_fast = (cnt_inc <= {1'b0, freq_eff});
    assign status.div_last  = (step_reg == STEP_W'(DVD_W - 1));

    // return store
    ssrs_ram #(
        .WIDTH (SITE_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (top_reg[AW-1:0]),
        .wdata (site_addr),
        .re    (cmd.pop),
        .raddr (top_dec[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        top_next = top_reg;
        if (cmd.push)
        begin
            top_next = top_reg + PW'(1);
        end
        else if (cmd.pop)
        begin
            top_next = top_dec;
        end
    end

    // restoring remainder, one dividend bit a step
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, freq_eff};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        if (cmd.div_start)
        begin
            rem_next  = '0;
            dvd_next  = cnt_inc;
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next  = (trial >= {1'b0, freq_eff}) ? trial_sub[CNT_W-1:0]
                                                    : trial[CNT_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
        end
        if (cmd.cnt_fast)
        begin
            cnt_next = (cnt_inc == {1'b0, freq_eff}) ? '0 : cnt_inc[CNT_W-1:0];
        end
        else if (cmd.div_wr)
        begin
            cnt_next = rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            cnt_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            cnt_reg  <= cnt_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        res_reg <= res_next;
        if (cmd.pop)
        begin
            site_reg <= site_addr;
        end
    end

    // result
    assign cmp_mis = (rdata != site_reg);

    always_comb
    begin
        res_next = res_reg;
        if (cmd.res_imm)
        begin
            res_next.mismatch     = 1'b0;
            res_next.error_action = ACT_NONE;
            res_next.stack_fault  = cmd.res_fault;
        end
        else if (cmd.res_cmp)
        begin
            res_next.mismatch     = cmp_mis;
            res_next.error_action = cmp_mis ? action_for_mode(mode_reg) : ACT_NONE;
            res_next.stack_fault  = 1'b0;
        end
    end

    assign res = res_reg;

endmodule

FILE: src/ssrs_ctrl.sv
// ---------------------------------------------------------------------------
// ssrs_ctrl - shadow stack controller
// Sequences one item at a time: decide, optional compare or remainder
// run, then hold the result until taken.
// ---------------------------------------------------------------------------
module ssrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ssrs_pkg::status_t   status,
    output ssrs_pkg::cmd_t      cmd
);
    import ssrs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ovld_reg, ovld_next;
    logic       acc;
    logic       done;

    assign in_ready = (state_reg == ST_IDLE) && !ovld_reg;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (status.is_call)
                    begin
                        cmd.push      = status.active && !status.full;
                        cmd.res_imm   = 1'b1;
                        cmd.res_fault = status.active && status.full;
                        done          = 1'b1;
                    end
                    else if (status.is_ret)
                    begin
                        if (status.active && !status.empty)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = ST_CMP;
                        end
                        else
                        begin
                            cmd.res_imm   = 1'b1;
                            cmd.res_fault = status.active;
                            done          = 1'b1;
                        end
                    end
                    else if (status.is_tick)
                    begin
                        if (status.tick_fast)
                        begin
                            cmd.cnt_fast = 1'b1;
                            cmd.res_imm  = 1'b1;
                            done         = 1'b1;
                        end
                        else
                        begin
                            // counter at or above the wrap value, left there by a reconfig
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    else
                    begin
                        cmd.res_imm = 1'b1;
                        done        = 1'b1;
                    end
                end
            end
            ST_CMP:
            begin
                cmd.res_cmp = 1'b1;
                done        = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    cmd.div_wr  = 1'b1;
                    cmd.res_imm = 1'b1;
                    done        = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovld_next = ovld_reg;
        if (done)
        begin
            ovld_next = 1'b1;
        end
        else if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign out_valid = ovld_reg;

endmodule

FILE: sim/sampled_shadow_return_stack_unit_tb.sv
// ---------------------------------------------------------------------------
// sampled_shadow_return_stack_unit_tb - self-checking bench for the sampled
// shadow return stack
// Drives call, return and job-tick events into the event stream. Each
// accepted event is also applied to a cycle-free shadow-stack predictor,
// which queues the verdict it expects. Every result item is checked
// against the oldest queued verdict. Short directed checks come first,
// then randomised phases of nested, filling and unwinding call sequences
// under changing register settings and handshake pressure.
// ---------------------------------------------------------------------------
module sampled_shadow_return_stack_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssrs_pkg::*;

    localparam int DEPTH = 128;

    // codes with no named meaning in the package
    localparam logic [1:0] OP_SPARE   = 2'd3;  // undefined event, ignored
    localparam logic [1:0] REG_SPARE  = 2'd3;  // no register, write dropped
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;  // undefined mode: flag, no action

    // random phase shapes
    localparam int SHAPE_FILL   = 0;  // mostly calls, runs into a full stack
    localparam int SHAPE_NEST   = 1;  // balanced calls and returns
    localparam int SHAPE_UNWIND = 2;  // mostly returns, runs into an empty stack
    localparam int SHAPE_NOISE  = 3;  // any event kind with any address

    localparam int unsigned ITEM_GOAL = 1050;

    // -----------------------------------------------------------------------
    // Verdict predictor and store of expected verdicts
    // -----------------------------------------------------------------------
    class shadow_stack_scoreboard;
        logic [SITE_W-1:0] frames [DEPTH];
        int unsigned       depth;
        logic [CNT_W-1:0]  job_count;
        logic              enable;
        logic [CNT_W-1:0]  wrap;
        logic [1:0]        mode;
        res_t              verdicts [$];
        int unsigned       faults;

        function new();
            depth     = 0;
            job_count = '0;
            enable    = 1'b0;
            wrap      = 16'd1;
            mode      = MODE_NONE;
            faults    = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_CHECK_ENABLE:    enable = data[0];
                REG_CHECK_FREQUENCY: wrap   = data;
                REG_ERROR_MODE:      mode   = data[1:0];
                default:             ;
            endcase
        endfunction

        // Applies one accepted event and queues its verdict.
        // Returns 1 when the event does anything at all.
        function bit apply_event(input logic [1:0] op, input logic [SITE_W-1:0] site);
            res_t        v;
            bit          live;
            bit          acted;
            int unsigned div;
            v     = '0;
            live  = enable && (job_count == '0);
            acted = 1'b0;
            case (op)
                OP_CALL:
                    if (live)
                    begin
                        acted = 1'b1;
                        if (depth >= DEPTH)
                            v.stack_fault = 1'b1;
                        else
                        begin
                            frames[depth] = site;
                            depth++;
                        end
                    end
                OP_RETURN:
                    if (live)
                    begin
                        acted = 1'b1;
                        if (depth == 0)
                            v.stack_fault = 1'b1;
                        else
                        begin
                            depth--;
                            if (frames[depth] !== site)
                            begin
                                v.mismatch = 1'b1;
                                case (mode)
                                    MODE_SUSPEND: v.error_action = ACT_SUSPEND;
                                    MODE_PAUSE:   v.error_action = ACT_PAUSE;
                                    default:      v.error_action = ACT_NONE;
                                endcase
                            end
                        end
                    end
                OP_TICK:
                begin
                    acted     = 1'b1;
                    div       = (wrap == '0) ? 1 : wrap;
                    job_count = CNT_W'((32'(job_count) + 1) % div);
                end
                default: ;
            endcase
            verdicts.push_back(v);
            return acted;
        endfunction

        function logic [SITE_W-1:0] top_site(input logic [SITE_W-1:0] fallback);
            return (depth == 0) ? fallback : frames[depth-1];
        endfunction

        function void note_fault(input string msg);
            faults++;
            if (faults <= 10)
                $display("%0t ns: %s", $time, msg);
        endfunction

        function void check_result(input res_t got);
            res_t want;
            if (verdicts.size() == 0)
            begin
                note_fault($sformatf("unexpected result item mis=%b act=%0d fault=%b",
                                     got.mismatch, got.error_action, got.stack_fault));
                return;
            end
            want = verdicts.pop_front();
            if (got.mismatch !== want.mismatch || got.error_action !== want.error_action ||
                got.stack_fault !== want.stack_fault)
                note_fault($sformatf({"result mismatch: expected mis=%b act=%0d fault=%b,",
                                      " got mis=%b act=%0d fault=%b"},
                                     want.mismatch, want.error_action, want.stack_fault,
                                     got.mismatch, got.error_action, got.stack_fault));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals; every input of the block starts at a known value
    // -----------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SITE_W-1:0]     s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DAT_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    int unsigned src_idle_pct = 0;   // chance per cycle that the sender holds off
    int unsigned snk_stall_pct = 0;  // chance per cycle that the receiver stalls
    int unsigned sent_items = 0;     // accepted events, directed ones included

    shadow_stack_scoreboard sb = new();

    sampled_shadow_return_stack_unit #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: ready is redrawn every cycle, so stalls land on every phase
    // of the block's work, including the held result of a slow tick.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    // Result monitor; sampled at the edge, so it sees pre-edge values.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(res_t'(m_tdata[RES_W-1:0]));

    // Hard limit of 5 ms. The run is about 1050 events, each with a full
    // remainder run at worst plus random sender gaps and receiver stalls.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Drivers; each is entered and left on a rising edge
    // -----------------------------------------------------------------------

    // One event item. Valid stays high into the next call unless the
    // sender decides to idle, so back-to-back items never drop valid.
    task automatic send_event(input logic [1:0] op, input logic [SITE_W-1:0] site);
        s_tvalid <= 1'b1;
        s_tuser  <= IN_USER_W'(op);
        s_tdata  <= site;
        do @(posedge clk); while (!s_tready);
        void'(sb.apply_event(op, site));
        sent_items++;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding verdict. Every event
    // yields one result, so the block is idle once the queue is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SITE_W-1:0] any_site();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_event(input int shape);
        int unsigned       roll;
        logic [1:0]        op;
        logic [SITE_W-1:0] site;
        roll = $urandom_range(99);
        case (shape)
            SHAPE_FILL:
                op = (roll < 93) ? OP_CALL : (roll < 97) ? OP_RETURN : OP_TICK;
            SHAPE_NEST:
                op = (roll < 45) ? OP_CALL : (roll < 85) ? OP_RETURN :
                     (roll < 96) ? OP_TICK : OP_SPARE;
            SHAPE_UNWIND:
                op = (roll < 85) ? OP_RETURN : (roll < 93) ? OP_CALL : OP_TICK;
            default:
                op = 2'($urandom_range(3));
        endcase
        site = any_site();
        // most returns name the address on top, so matches dominate
        if (op == OP_RETURN && $urandom_range(99) < 75)
            site = sb.top_site(site);
        send_event(op, site);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int          phase;
        int          shape;
        int          len;
        logic        en;
        logic [1:0]  mode;
        logic [15:0] freq;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: checking off. Calls and returns do nothing, the
        // tick steps the counter (wrapping to zero), the undefined event is ignored.
        send_event(OP_CALL, '1);
        send_event(OP_RETURN, '1);
        send_event(OP_TICK, '0);
        send_event(OP_SPARE, '1);
        settle();

        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_CHECK_ENABLE, 16'h0001);
        write_reg(REG_ERROR_MODE, 16'(MODE_SUSPEND));

        // return on an empty stack: fault, no compare
        send_event(OP_RETURN, 32'h1234_5678);
        // push both extremes, then pop straight after a push
        send_event(OP_CALL, '1);
        send_event(OP_CALL, '0);
        send_event(OP_RETURN, '0);
        send_event(OP_RETURN, 32'h1234_5678);   // mismatch, suspend
        send_event(OP_SPARE, '0);
        settle();

        write_reg(REG_ERROR_MODE, 16'(MODE_PAUSE));
        send_event(OP_CALL, 32'hA5A5_5A5A);
        send_event(OP_RETURN, 32'h5A5A_A5A5);   // mismatch, pause
        settle();

        // undefined mode: the mismatch is flagged but no action given
        write_reg(REG_ERROR_MODE, 16'(MODE_SPARE));
        send_event(OP_CALL, 32'h0000_0004);
        send_event(OP_RETURN, 32'h8000_0004);
        settle();

        // frequency zero behaves as one: the counter never leaves zero
        write_reg(REG_CHECK_FREQUENCY, 16'h0000);
        send_event(OP_TICK, 32'h0F0F_0F0F);
        send_event(OP_CALL, 32'hDEAD_BEEF);
        send_event(OP_RETURN, 32'hDEAD_BEEF);
        settle();

        // park the counter at 5, then shrink the wrap below it: the next
        // tick takes the slow remainder path back to zero
        write_reg(REG_CHECK_FREQUENCY, 16'd10);
        repeat (5) send_event(OP_TICK, $urandom());
        send_event(OP_CALL, 32'h0000_1000);     // ignored, counter non-zero
        settle();
        write_reg(REG_CHECK_FREQUENCY, 16'd3);
        send_event(OP_TICK, $urandom());
        send_event(OP_CALL, 32'h0000_2000);
        send_event(OP_RETURN, 32'h0000_2000);
        settle();

        // Random phases. Each picks a sequence shape, register settings and
        // a handshake pressure profile; the last phase is cut to the goal.
        phase = 0;
        while (sent_items < ITEM_GOAL)
        begin
            shape = $urandom_range(3);
            en    = (shape == SHAPE_FILL) ? 1'b1 : ($urandom_range(9) != 0);
            mode  = 2'($urandom_range(3));
            case ($urandom_range(9))
                0:       freq = 16'h0000;
                1:       freq = 16'hFFFF;
                2, 3:    freq = 16'($urandom_range(2, 4));
                default: freq = 16'd1;
            endcase
            if (shape == SHAPE_FILL)
                freq = 16'd1;   // keep the counter at zero so the stack fills

            write_reg(REG_CHECK_ENABLE, {15'($urandom()), en});
            write_reg(REG_CHECK_FREQUENCY, freq);
            write_reg(REG_ERROR_MODE, {14'($urandom()), mode});
            if ($urandom_range(7) == 0)
                write_reg(REG_SPARE, 16'($urandom()));

            case (phase % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 54; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 54; end
                default: begin src_idle_pct = 13; snk_stall_pct = 13; end
            endcase

            len = (shape == SHAPE_FILL) ? 150 : $urandom_range(20, 70);
            if (len > int'(ITEM_GOAL - sent_items))
                len = int'(ITEM_GOAL - sent_items);
            repeat (len) random_event(shape);
            settle();
            phase++;
        end

        // allow for anything the block might still emit
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (20) @(posedge clk);

        if (sb.faults == 0 && sb.verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sampled_shadow_return_stack_unit.f
src/ssrs_pkg.sv
src/ssrs_ram.sv
src/ssrs_dp.sv
src/ssrs_ctrl.sv
src/sampled_shadow_return_stack_unit.sv
sim/sampled_shadow_return_stack_unit_tb.sv
